/* sv/rlbt_pkg.sv */
// Shared constants and types for the run-length bitmap table.
// Used by rlbt_ctrl, rlbt_dp and run_length_bitmap_table_core; no dependencies.
package rlbt_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_RUNS_DEF = 256;
	localparam int POS_BITS_DEF = 20;

	// Request codes.
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_TEST   = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_FILL   = 2'd3;

	// Error codes.
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_RANGE = 2'd1;
	localparam logic [1:0] ERR_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic exec;
		logic srch_init;
		logic srch_step;
		logic chk;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] req_code;
		logic       test_skip;
		logic       srch_done;
	} status_t;

endpackage

/* sv/rlbt_ctrl.sv */
// Controller state machine for the run-length bitmap table.
// Depends on rlbt_pkg for the command and status types and the request codes.
module rlbt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  rlbt_pkg::status_t   status,
	output rlbt_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_SRD  = 3'd2;
	localparam logic [2:0] ST_SCMP = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	// A new request is taken only when the sequencer is idle.
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.req_code == rlbt_pkg::REQ_TEST && !status.test_skip) begin
					cmd.srch_init = 1'b1;
					state_nxt     = ST_SRD;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_SRD: begin
				state_nxt = status.srch_done ? ST_CHK : ST_SCMP;
			end
			ST_SCMP: begin
				cmd.srch_step = 1'b1;
				state_nxt     = ST_SRD;
			end
			ST_CHK: begin
				cmd.chk   = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/rlbt_dp.sv */
// Datapath for the run-length bitmap table: run memory, summary registers,
// binary search registers and the result register. Depends on rlbt_pkg.
module rlbt_dp #(
	parameter int MAX_RUNS = rlbt_pkg::MAX_RUNS_DEF,
	parameter int POS_BITS = rlbt_pkg::POS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rlbt_pkg::cmd_t        cmd,
	output rlbt_pkg::status_t     status,
	input  logic                  cfg_we,
	input  logic [POS_BITS:0]     cfg_data,
	input  logic [1:0]            req_type,
	input  logic [POS_BITS-1:0]   start_pos,
	input  logic [POS_BITS-1:0]   end_pos,
	output logic                  hit,
	output logic [1:0]            error_code,
	output logic [POS_BITS:0]     bits_set,
	output logic                  is_empty,
	output logic                  is_full,
	output logic [POS_BITS-1:0]   first_set_pos,
	output logic                  first_set_valid,
	output logic [POS_BITS-1:0]   first_clear_pos,
	output logic                  first_clear_valid
);

	localparam int RUN_BITS = $clog2(MAX_RUNS);
	localparam logic [RUN_BITS-1:0] LAST_SLOT = RUN_BITS'(MAX_RUNS - 1);
	localparam logic [POS_BITS:0]   SIZE_MAX  = {1'b1, {POS_BITS{1'b0}}};

	// Run memory, one write port and one registered read port.
	logic [POS_BITS-1:0] start_mem [MAX_RUNS];
	logic [POS_BITS:0]   len_mem   [MAX_RUNS];

	logic [POS_BITS:0]   size_q;
	logic [1:0]          req_q;
	logic [POS_BITS-1:0] s_q;
	logic [POS_BITS-1:0] e_q;
	logic [RUN_BITS-1:0] last_q;
	logic [POS_BITS-1:0] hsp_q;
	logic [POS_BITS:0]   count_q;
	logic [POS_BITS:0]   last_len_q;
	logic [POS_BITS-1:0] run0_start_q;
	logic [POS_BITS:0]   run0_len_q;
	logic [RUN_BITS-1:0] lo_q;
	logic [RUN_BITS-1:0] hi_q;
	logic [POS_BITS-1:0] rd_start_q;
	logic [POS_BITS:0]   rd_len_q;
	logic                hit_q;
	logic [1:0]          err_q;

	logic [RUN_BITS:0]   mid_sum;
	logic [RUN_BITS-1:0] mid;
	logic [RUN_BITS-1:0] rd_addr;
	logic                empty_w;
	logic                full_w;

	// Append decision signals.
	logic                bad_range;
	logic                do_add;
	logic [POS_BITS-1:0] new_s;
	logic [POS_BITS:0]   add_len;
	logic [POS_BITS:0]   ext_len;
	logic                extend;
	logic                table_full;
	logic                wr_start;
	logic                wr_len;
	logic [RUN_BITS-1:0] wr_addr;
	logic [POS_BITS-1:0] wr_start_data;
	logic [POS_BITS:0]   wr_len_data;
	logic                hit_w;

	// Midpoint rounds up so the lower bound always moves.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (RUN_BITS+1)'(1);
	assign mid     = mid_sum[RUN_BITS:1];
	assign rd_addr = (lo_q == hi_q) ? lo_q : mid;

	assign empty_w = (count_q == '0);
	assign full_w  = (count_q >= size_q);

	assign status.req_code  = req_q;
	assign status.test_skip = empty_w || (s_q > hsp_q);
	assign status.srch_done = (lo_q == hi_q);

	// Append range checks and trimming against the highest set bit.
	always_comb begin
		bad_range  = (s_q > e_q) || ({1'b0, e_q} >= size_q);
		do_add     = 1'b0;
		new_s      = s_q;
		if (!bad_range) begin
			if (empty_w || hsp_q < s_q) begin
				do_add = 1'b1;
			end else if (hsp_q < e_q) begin
				do_add = 1'b1;
				new_s  = hsp_q + POS_BITS'(1);
			end
		end
		add_len    = {1'b0, e_q - new_s} + (POS_BITS+1)'(1);
		ext_len    = last_len_q + add_len;
		extend     = !empty_w && ({1'b0, new_s} == {1'b0, hsp_q} + (POS_BITS+1)'(1));
		table_full = !empty_w && !extend && (last_q == LAST_SLOT);
	end

	// Memory write selection for append and fill.
	always_comb begin
		wr_start      = 1'b0;
		wr_len        = 1'b0;
		wr_addr       = last_q;
		wr_start_data = new_s;
		wr_len_data   = add_len;
		if (cmd.exec) begin
			case (req_q)
				rlbt_pkg::REQ_APPEND: begin
					if (do_add) begin
						if (empty_w) begin
							wr_start = 1'b1;
							wr_len   = 1'b1;
							wr_addr  = '0;
						end else if (extend) begin
							wr_len      = 1'b1;
							wr_len_data = ext_len;
						end else if (!table_full) begin
							wr_start = 1'b1;
							wr_len   = 1'b1;
							wr_addr  = last_q + RUN_BITS'(1);
						end
					end
				end
				rlbt_pkg::REQ_FILL: begin
					wr_start      = 1'b1;
					wr_len        = 1'b1;
					wr_addr       = '0;
					wr_start_data = '0;
					wr_len_data   = size_q;
				end
				default: begin
					wr_start = 1'b0;
				end
			endcase
		end
	end

	// Run memory write and registered read.
	always_ff @(posedge clk) begin
		if (wr_start) begin
			start_mem[wr_addr] <= wr_start_data;
		end
		if (wr_len) begin
			len_mem[wr_addr] <= wr_len_data;
		end
		rd_start_q <= start_mem[rd_addr];
		rd_len_q   <= len_mem[rd_addr];
	end

	// Final containment check on the candidate run.
	assign hit_w = (rd_start_q <= s_q) && ({1'b0, s_q - rd_start_q} < rd_len_q);

	// Request capture and search bounds.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_type;
			s_q   <= start_pos;
			e_q   <= end_pos;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= last_q;
		end else if (cmd.srch_step) begin
			if (rd_start_q <= s_q) begin
				lo_q <= mid;
			end else begin
				hi_q <= mid - RUN_BITS'(1);
			end
		end
		if (cmd.exec) begin
			hit_q <= 1'b0;
			err_q <= rlbt_pkg::ERR_NONE;
			if (req_q == rlbt_pkg::REQ_APPEND) begin
				if (bad_range) begin
					err_q <= rlbt_pkg::ERR_RANGE;
				end else if (do_add && table_full) begin
					err_q <= rlbt_pkg::ERR_FULL;
				end
			end
		end else if (cmd.chk) begin
			hit_q <= hit_w;
		end
	end

	// Bitmap summary state and size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q       <= SIZE_MAX;
			last_q       <= '0;
			hsp_q        <= '0;
			count_q      <= '0;
			last_len_q   <= '0;
			run0_start_q <= '0;
			run0_len_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_data == '0) begin
					size_q <= (POS_BITS+1)'(1);
				end else if (cfg_data > SIZE_MAX) begin
					size_q <= SIZE_MAX;
				end else begin
					size_q <= cfg_data;
				end
			end
			if (cmd.exec) begin
				case (req_q)
					rlbt_pkg::REQ_APPEND: begin
						if (do_add && !table_full) begin
							count_q <= count_q + add_len;
							hsp_q   <= e_q;
							if (empty_w) begin
								last_q       <= '0;
								last_len_q   <= add_len;
								run0_start_q <= new_s;
								run0_len_q   <= add_len;
							end else if (extend) begin
								last_len_q <= ext_len;
								if (last_q == '0) begin
									run0_len_q <= ext_len;
								end
							end else begin
								last_q     <= last_q + RUN_BITS'(1);
								last_len_q <= add_len;
							end
						end
					end
					rlbt_pkg::REQ_CLEAR: begin
						last_q       <= '0;
						hsp_q        <= '0;
						count_q      <= '0;
						last_len_q   <= '0;
						run0_start_q <= '0;
						run0_len_q   <= '0;
					end
					rlbt_pkg::REQ_FILL: begin
						last_q       <= '0;
						hsp_q        <= POS_BITS'(size_q - (POS_BITS+1)'(1));
						count_q      <= size_q;
						last_len_q   <= size_q;
						run0_start_q <= '0;
						run0_len_q   <= size_q;
					end
					default: begin
						last_q <= last_q;
					end
				endcase
			end
		end
	end

	// Result register, loaded once the request has finished.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit               <= hit_q;
			error_code        <= err_q;
			bits_set          <= count_q;
			is_empty          <= empty_w;
			is_full           <= full_w;
			first_set_pos     <= empty_w ? '0 : run0_start_q;
			first_set_valid   <= !empty_w;
			first_clear_pos   <= (full_w || empty_w || run0_start_q != '0) ?
				'0 : run0_len_q[POS_BITS-1:0];
			first_clear_valid <= !full_w;
		end
	end

endmodule

/* sv/run_length_bitmap_table_core.sv */
// Top level of the run-length bitmap table: controller plus datapath.
// Depends on rlbt_pkg, rlbt_ctrl and rlbt_dp.
//
//  Channel   Handshake             Payload
//  input     in_valid / in_stall   req_type, start_pos, end_pos
//  output    out_valid / out_stall hit, error_code, bits_set, flags, first positions
//  config    cfg_valid / cfg_ready bitmap_size
//
// Append, clear and fill pass through EXEC and DONE before the result register
// is loaded. A test that is not skipped then runs a binary search, alternating
// SRD and SCMP over the single read port of the run memory, then CHK and DONE.
// Reset empties the table and sets the size to its maximum; no memory sweep.
// A new request is taken as soon as the previous one is in the result register.
module run_length_bitmap_table_core #(
	parameter int MAX_RUNS = rlbt_pkg::MAX_RUNS_DEF,
	parameter int POS_BITS = rlbt_pkg::POS_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [POS_BITS-1:0] start_pos,
	input  logic [POS_BITS-1:0] end_pos,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [1:0]          error_code,
	output logic [POS_BITS:0]   bits_set,
	output logic                is_empty,
	output logic                is_full,
	output logic [POS_BITS-1:0] first_set_pos,
	output logic                first_set_valid,
	output logic [POS_BITS-1:0] first_clear_pos,
	output logic                first_clear_valid,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [POS_BITS:0]   bitmap_size
);

	rlbt_pkg::cmd_t    cmd;
	rlbt_pkg::status_t status;

	// The size register takes a transfer in any cycle.
	assign cfg_ready = 1'b1;

	rlbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rlbt_dp #(
		.MAX_RUNS (MAX_RUNS),
		.POS_BITS (POS_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_data          (bitmap_size),
		.req_type          (req_type),
		.start_pos         (start_pos),
		.end_pos           (end_pos),
		.hit               (hit),
		.error_code        (error_code),
		.bits_set          (bits_set),
		.is_empty          (is_empty),
		.is_full           (is_full),
		.first_set_pos     (first_set_pos),
		.first_set_valid   (first_set_valid),
		.first_clear_pos   (first_clear_pos),
		.first_clear_valid (first_clear_valid)
	);

`ifndef SYNTHESIS
	// The empty flag agrees with the set-bit count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (bits_set == '0)))
		else $error("is_empty disagrees with bits_set");

	// The first set bit is reported exactly when the bitmap is not empty.
	a_first_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (first_set_valid != is_empty))
		else $error("first_set_valid disagrees with is_empty");

	// A hit can only come from a non-empty table without error.
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (!is_empty && error_code == rlbt_pkg::ERR_NONE))
		else $error("hit reported on empty table or with error");

	// An accepted request keeps the input side busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transfer");
`endif

endmodule

/* tb/sv/tb_run_length_bitmap_table_core.sv */
// Testbench for run_length_bitmap_table_core: random and directed requests with a scoreboard.
// Depends on rlbt_pkg and the RTL of run_length_bitmap_table_core.
`timescale 1ns / 100ps

// Keeps its own copy of the run table and the expected results in order.
class rlbt_scoreboard;
	typedef struct packed {
		logic        hit;
		logic [1:0]  error_code;
		logic [20:0] bits_set;
		logic        is_empty;
		logic        is_full;
		logic [19:0] first_set_pos;
		logic        first_set_valid;
		logic [19:0] first_clear_pos;
		logic        first_clear_valid;
	} result_t;

	logic [19:0] run_start [256];
	logic [20:0] run_len [256];
	int unsigned last_run;
	logic [19:0] high_pos;
	logic [20:0] set_count;
	logic [20:0] size_reg;
	result_t pending_results[$];
	int unsigned errors;

	function new();
		last_run = 0;
		high_pos = 0;
		set_count = 0;
		size_reg = 21'd1048576;
		errors = 0;
		run_start[0] = 0;
		run_len[0] = 0;
	endfunction

	function longint eff_size();
		if (size_reg == 0) return 1;
		if (size_reg > 21'd1048576) return 1048576;
		return longint'(size_reg);
	endfunction

	// Adds a range that lies above the highest set bit; returns the error code.
	function logic [1:0] add_range(longint s, longint e);
		longint len;
		len = e - s + 1;
		if (set_count == 0) begin
			last_run = 0;
			run_start[0] = 20'(s);
			run_len[0] = 21'(len);
		end else if (s == longint'(high_pos) + 1) begin
			run_len[last_run] = 21'(run_len[last_run] + len);
		end else begin
			if (last_run + 1 >= 256) return rlbt_pkg::ERR_FULL;
			last_run++;
			run_start[last_run] = 20'(s);
			run_len[last_run] = 21'(len);
		end
		set_count = 21'(set_count + len);
		high_pos = 20'(e);
		return rlbt_pkg::ERR_NONE;
	endfunction

	// Notes an accepted request and queues the result it must produce.
	function void note_request(logic [1:0] req, logic [19:0] s, logic [19:0] e);
		result_t r;
		longint sz;
		r = '0;
		sz = eff_size();
		case (req)
			rlbt_pkg::REQ_APPEND: begin
				if (s > e || e >= sz) r.error_code = rlbt_pkg::ERR_RANGE;
				else if (set_count == 0 || high_pos < s) r.error_code = add_range(s, e);
				else if (high_pos < e) r.error_code = add_range(longint'(high_pos) + 1, e);
			end
			rlbt_pkg::REQ_TEST: begin
				if (set_count != 0 && s <= high_pos)
					for (int i = 0; i <= last_run; i++)
						if (run_start[i] <= s && longint'(s - run_start[i]) < run_len[i]) begin
							r.hit = 1;
							break;
						end
			end
			rlbt_pkg::REQ_CLEAR: begin
				last_run = 0;
				high_pos = 0;
				set_count = 0;
				run_start[0] = 0;
				run_len[0] = 0;
			end
			default: begin
				last_run = 0;
				run_start[0] = 0;
				run_len[0] = 21'(sz);
				set_count = 21'(sz);
				high_pos = 20'(sz - 1);
			end
		endcase
		r.bits_set = set_count;
		r.is_empty = (set_count == 0);
		r.is_full = (set_count >= sz);
		r.first_set_valid = !r.is_empty;
		r.first_set_pos = r.is_empty ? 20'd0 : run_start[0];
		r.first_clear_valid = !r.is_full;
		if (r.is_full || r.is_empty || run_start[0] != 0) r.first_clear_pos = '0;
		else r.first_clear_pos = 20'(run_start[0] + run_len[0]);
		pending_results.push_back(r);
	endfunction

	// Compares one accepted result with the oldest expectation.
	function void check_result(result_t act);
		result_t exp_r;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %h", $time, act);
			errors++;
			return;
		end
		exp_r = pending_results.pop_front();
		if (exp_r.hit != act.hit) report("hit", exp_r.hit, act.hit);
		if (exp_r.error_code != act.error_code)
			report("error_code", exp_r.error_code, act.error_code);
		if (exp_r.bits_set != act.bits_set) report("bits_set", exp_r.bits_set, act.bits_set);
		if (exp_r.is_empty != act.is_empty) report("is_empty", exp_r.is_empty, act.is_empty);
		if (exp_r.is_full != act.is_full) report("is_full", exp_r.is_full, act.is_full);
		if (exp_r.first_set_pos != act.first_set_pos)
			report("first_set_pos", exp_r.first_set_pos, act.first_set_pos);
		if (exp_r.first_set_valid != act.first_set_valid)
			report("first_set_valid", exp_r.first_set_valid, act.first_set_valid);
		if (exp_r.first_clear_pos != act.first_clear_pos)
			report("first_clear_pos", exp_r.first_clear_pos, act.first_clear_pos);
		if (exp_r.first_clear_valid != act.first_clear_valid)
			report("first_clear_valid", exp_r.first_clear_valid, act.first_clear_valid);
	endfunction

	function void report(string field, longint exp_v, longint act_v);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
		errors++;
	endfunction
endclass

module tb_run_length_bitmap_table_core;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  req_type = rlbt_pkg::REQ_CLEAR;
	logic [19:0] start_pos = 0;
	logic [19:0] end_pos = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        hit;
	logic [1:0]  error_code;
	logic [20:0] bits_set;
	logic        is_empty;
	logic        is_full;
	logic [19:0] first_set_pos;
	logic        first_set_valid;
	logic [19:0] first_clear_pos;
	logic        first_clear_valid;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [20:0] bitmap_size = 21'd1048576;

	rlbt_scoreboard bitmap_sb = new();
	int unsigned idle_cycles = 0;
	bit          hold_off = 0;
	logic [19:0] next_pos = 0;

	always #5 clk = ~clk;

	run_length_bitmap_table_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .start_pos(start_pos), .end_pos(end_pos),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .error_code(error_code), .bits_set(bits_set),
		.is_empty(is_empty), .is_full(is_full),
		.first_set_pos(first_set_pos), .first_set_valid(first_set_valid),
		.first_clear_pos(first_clear_pos), .first_clear_valid(first_clear_valid),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .bitmap_size(bitmap_size)
	);

	// Note each input transfer and check each output transfer at the clock edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			bitmap_sb.note_request(req_type, start_pos, end_pos);
		if (arst_n && out_valid && !out_stall)
			bitmap_sb.check_result({hit, error_code, bits_set, is_empty, is_full,
				first_set_pos, first_set_valid, first_clear_pos, first_clear_valid});
	end

	// Receiver stall pattern, with a long hold-off when asked for.
	always @(posedge clk) begin
		int unsigned mode;
		mode = int'(($time / 4000) % 3);
		if (hold_off) out_stall <= 1;
		else if (mode == 0) out_stall <= 0;
		else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= ($urandom_range(0, 1) == 0);
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
				|| hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one request after the given gap and waits for its transfer.
	// The valid line is left high for the next request or for drain to lower.
	task automatic send_req(logic [1:0] req, logic [19:0] s, logic [19:0] e, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		req_type <= req;
		start_pos <= s;
		end_pos <= e;
		do @(posedge clk); while (in_stall);
	endtask

	// Sends one request with no gap, so that successive calls follow back to back.
	task automatic send_burst(logic [1:0] req, logic [19:0] s, logic [19:0] e);
		in_valid <= 1;
		req_type <= req;
		start_pos <= s;
		end_pos <= e;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every expected result has arrived, then some settling cycles.
	task automatic drain();
		in_valid <= 0;
		while (bitmap_sb.pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_size(logic [20:0] v);
		cfg_valid <= 1;
		bitmap_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		bitmap_sb.size_reg = v;
	endtask

	// Picks a random request: appends moving up the bitmap, tests, stray appends, clears, fills.
	task automatic random_req(output logic [1:0] req, output logic [19:0] s,
			output logic [19:0] e);
		longint sz;
		int unsigned pick;
		sz = bitmap_sb.eff_size();
		pick = $urandom_range(0, 99);
		s = 20'($urandom());
		e = 20'($urandom());
		if (pick < 50) begin
			req = rlbt_pkg::REQ_APPEND;
			if ($urandom_range(0, 9) == 0 || longint'(next_pos) + 8 >= sz) begin
				next_pos = 0;
				req = rlbt_pkg::REQ_CLEAR;
			end else begin
				s = 20'(next_pos + $urandom_range(0, 2));
				if (longint'(s) >= sz) s = 20'(sz - 1);
				e = 20'(s + $urandom_range(0, 5));
				if (longint'(e) >= sz) e = 20'(sz - 1);
				if ($urandom_range(0, 4) == 0 && s > 3) s = 20'(s - 3);
				next_pos = 20'(e + 1);
			end
		end else if (pick < 85) begin
			req = rlbt_pkg::REQ_TEST;
			if ($urandom_range(0, 3) != 0) s = 20'($urandom_range(0, next_pos + 2));
		end else if (pick < 93) begin
			req = rlbt_pkg::REQ_APPEND;
		end else if (pick < 97) begin
			req = rlbt_pkg::REQ_CLEAR;
			next_pos = 0;
		end else begin
			req = rlbt_pkg::REQ_FILL;
			next_pos = 20'(sz - 1);
		end
	endtask

	// Bursts of random length with a random gap ahead of each burst.
	task automatic random_phase(int count);
		logic [1:0] req;
		logic [19:0] s, e;
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			while (burst > 0 && left > 0) begin
				random_req(req, s, e);
				send_req(req, s, e, gap);
				gap = 0;
				burst--;
				left--;
			end
		end
		drain();
	endtask

	initial begin
		logic [1:0] req;
		logic [19:0] s, e;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every request type, range errors, covered ranges.
		send_req(rlbt_pkg::REQ_TEST, 20'hFFFFF, 0, 0);
		send_req(rlbt_pkg::REQ_APPEND, 5, 4, 1);
		send_req(rlbt_pkg::REQ_APPEND, 0, 20'hFFFFF, 0);
		send_req(rlbt_pkg::REQ_TEST, 20'hFFFFF, 0, 0);
		send_req(rlbt_pkg::REQ_CLEAR, 0, 0, 2);
		send_req(rlbt_pkg::REQ_APPEND, 0, 0, 0);
		send_req(rlbt_pkg::REQ_APPEND, 1, 3, 0);
		send_req(rlbt_pkg::REQ_APPEND, 2, 9, 0);
		send_req(rlbt_pkg::REQ_APPEND, 1, 5, 0);
		send_req(rlbt_pkg::REQ_APPEND, 20, 30, 0);
		send_req(rlbt_pkg::REQ_TEST, 15, 0, 0);
		send_req(rlbt_pkg::REQ_TEST, 25, 0, 0);
		send_req(rlbt_pkg::REQ_TEST, 9, 0, 0);
		send_req(rlbt_pkg::REQ_FILL, 0, 0, 0);
		send_req(rlbt_pkg::REQ_TEST, 20'hAAAAA, 20'h55555, 0);
		drain();

		// Small size with lowering after writes, and size 0.
		write_size(21'd16);
		send_req(rlbt_pkg::REQ_APPEND, 3, 16, 0);
		send_req(rlbt_pkg::REQ_FILL, 0, 0, 0);
		drain();
		write_size(21'd0);
		send_req(rlbt_pkg::REQ_APPEND, 0, 0, 0);
		send_req(rlbt_pkg::REQ_FILL, 0, 0, 0);
		send_req(rlbt_pkg::REQ_CLEAR, 0, 0, 0);
		send_req(rlbt_pkg::REQ_APPEND, 0, 0, 0);
		drain();
		write_size(21'h1FFFFF);
		send_req(rlbt_pkg::REQ_FILL, 0, 0, 0);
		send_req(rlbt_pkg::REQ_TEST, 20'hFFFFF, 0, 0);
		send_req(rlbt_pkg::REQ_CLEAR, 0, 0, 0);
		drain();
		next_pos = 0;

		// Fill the run table to its limit with single-bit runs.
		write_size(21'd1048576);
		for (int i = 0; i < 258; i++)
			send_burst(rlbt_pkg::REQ_APPEND, 20'(2 * i), 20'(2 * i));
		for (int i = 0; i < 10; i++)
			send_req(rlbt_pkg::REQ_TEST, 20'($urandom_range(0, 520)), 0,
				$urandom_range(0, 2));
		drain();

		// Long receiver hold-off while requests keep coming.
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			begin
				next_pos = 0;
				for (int i = 0; i < 30; i++) begin
					random_req(req, s, e);
					send_burst(req, s, e);
				end
			end
		join
		drain();

		// Random phases at several sizes.
		random_phase(150);
		write_size(21'd40);
		next_pos = 0;
		send_req(rlbt_pkg::REQ_CLEAR, 0, 0, 0);
		random_phase(120);
		write_size(21'd1);
		random_phase(40);
		write_size(21'd1048576);
		send_req(rlbt_pkg::REQ_CLEAR, 0, 0, 0);
		next_pos = 0;
		random_phase(160);

		if (bitmap_sb.errors == 0 && bitmap_sb.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* sim.f */
sv/rlbt_pkg.sv
sv/rlbt_ctrl.sv
sv/rlbt_dp.sv
sv/run_length_bitmap_table_core.sv
tb/sv/tb_run_length_bitmap_table_core.sv
